@@ hdl/prq_pkg.sv @@
`default_nettype none

package prq_pkg;

  // Default depth of the task store
  localparam int QUEUE_DEPTH = 32;

  // Progress bar limits
  localparam logic [5:0] BAR_START = 6'd3;
  localparam logic [5:0] BAR_END   = 6'd33;

  // Request modes
  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_PREEMPT = 2'd2;

  // Result event codes
  localparam logic [2:0] EV_INSERTED  = 3'd0;
  localparam logic [2:0] EV_FULL      = 3'd1;
  localparam logic [2:0] EV_ADVANCED  = 3'd2;
  localparam logic [2:0] EV_FINISHED  = 3'd3;
  localparam logic [2:0] EV_PREEMPTED = 3'd4;
  localparam logic [2:0] EV_IDLE      = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] new_priority;
    logic [8:0] new_weight;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] task_id;
    logic [3:0]  task_priority;
    logic [6:0]  task_progress;
    logic [8:0]  task_weight;
    logic [5:0]  bar_position;
    logic [5:0]  queue_count;
  } rsp_item_t;

  // One entry of the task store
  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  prio;
    logic [6:0]  prog;
    logic [8:0]  wgt;
  } task_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INSERT,
    OP_REJECT,
    OP_IDLE_EMPTY,
    OP_IDLE,
    OP_TICK,
    OP_PREEMPT,
    OP_RD_HEAD,
    OP_DISPATCH,
    OP_SORT_RD_I,
    OP_SORT_LD_I,
    OP_SORT_CMP,
    OP_SORT_WB
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       empty;
    logic       running;
    logic       sort_due;
    logic       j_last;
    logic       i_last;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/prq_ctrl.sv @@
`default_nettype none

module prq_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_ready,
  input  prq_pkg::status_t  sts,
  output prq_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SORT_RD_I,
    S_SORT_LD_I,
    S_SORT_CMP,
    S_SORT_WB,
    S_RD_HEAD,
    S_DISPATCH,
    S_TICK
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.op     = prq_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
          case (sts.mode)
            prq_pkg::MODE_INSERT: begin
              cmd.op = sts.full ? prq_pkg::OP_REJECT : prq_pkg::OP_INSERT;
            end
            prq_pkg::MODE_TICK: begin
              if (sts.empty) begin
                cmd.op = prq_pkg::OP_IDLE_EMPTY;
              end else if (sts.running) begin
                cmd.op = prq_pkg::OP_TICK;
              end else if (sts.sort_due) begin
                state_next = S_SORT_RD_I;
              end else begin
                state_next = S_RD_HEAD;
              end
            end
            prq_pkg::MODE_PREEMPT: begin
              cmd.op = sts.running ? prq_pkg::OP_PREEMPT : prq_pkg::OP_IDLE;
            end
            default: begin
              cmd.op = prq_pkg::OP_IDLE;
            end
          endcase
        end
      end
      S_SORT_RD_I: begin
        cmd.op     = prq_pkg::OP_SORT_RD_I;
        state_next = S_SORT_LD_I;
      end
      S_SORT_LD_I: begin
        cmd.op     = prq_pkg::OP_SORT_LD_I;
        state_next = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd.op = prq_pkg::OP_SORT_CMP;
        if (sts.j_last) begin
          state_next = S_SORT_WB;
        end
      end
      S_SORT_WB: begin
        cmd.op     = prq_pkg::OP_SORT_WB;
        state_next = sts.i_last ? S_RD_HEAD : S_SORT_RD_I;
      end
      S_RD_HEAD: begin
        cmd.op     = prq_pkg::OP_RD_HEAD;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        cmd.op     = prq_pkg::OP_DISPATCH;
        state_next = S_TICK;
      end
      S_TICK: begin
        if (sts.out_free) begin
          cmd.op     = prq_pkg::OP_TICK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/prq_dpath.sv @@
`default_nettype none

module prq_dpath #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  prq_pkg::cmd_t        cmd,
  input  prq_pkg::req_item_t   req_data,
  input  wire                  rsp_ready,
  output prq_pkg::status_t     sts,
  output logic                 rsp_valid,
  output prq_pkg::rsp_item_t   rsp_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // floor(x/10) = (x*205) >> 11 for x below 1029
  localparam logic [16:0] RECIP_TEN   = 17'd205;
  // floor(x/3) = (x*171) >> 9 for x up to 300
  localparam logic [15:0] RECIP_THREE = 16'd171;

  // Circular store: logical slot x lives at (head + x) mod depth
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] x);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(x);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return IDX_W'(s);
  endfunction

  prq_pkg::task_t mem [QUEUE_DEPTH];
  prq_pkg::task_t rd_data;

  prq_pkg::req_item_t item;
  prq_pkg::task_t     hd;
  prq_pkg::task_t     cur;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   si;
  logic [CNT_W-1:0]   sj;
  logic [15:0]        next_id;
  logic               needs_sort;
  logic               running;
  logic [5:0]         bar;

  logic             we;
  logic [IDX_W-1:0] wa;
  prq_pkg::task_t   wd;
  logic [IDX_W-1:0] ra;

  prq_pkg::task_t new_task;
  prq_pkg::task_t hd_saved;
  logic [5:0]     bar_adv;
  logic [5:0]     bar_idle;
  logic           do_swap;
  logic [5:0]     cnt_plus;
  logic [5:0]     cnt_minus;
  logic           emit;

  // Dispatch recovery: 3 + 3p/10, saturated at the bar end
  logic [8:0]  p3;
  logic [16:0] p3_prod;
  logic [6:0]  start_sum;
  logic [5:0]  bar_start;

  // Preempt save: (pos-3)*10/3
  logic [5:0]  span;
  logic [8:0]  span10;
  logic [15:0] save_prod;

  always_comb begin
    new_task.id   = next_id;
    new_task.prio = (item.new_priority == 4'd0) ? 4'd1 : item.new_priority;
    new_task.prog = 7'd0;
    new_task.wgt  = item.new_weight;

    bar_adv  = (bar < prq_pkg::BAR_END) ? bar + 6'd1 : bar;
    bar_idle = running ? bar : 6'd0;
    do_swap  = (cur.prio > rd_data.prio);

    cnt_plus  = 6'(count + CNT_W'(1));
    cnt_minus = 6'(count - CNT_W'(1));

    p3        = {2'b00, rd_data.prog} + {1'b0, rd_data.prog, 1'b0};
    p3_prod   = 17'(p3) * RECIP_TEN;
    start_sum = 7'(prq_pkg::BAR_START) + {1'b0, p3_prod[16:11]};
    bar_start = (start_sum > 7'(prq_pkg::BAR_END)) ? prq_pkg::BAR_END : start_sum[5:0];

    span      = bar_adv - prq_pkg::BAR_START;
    span10    = {span, 3'b000} + {2'b00, span, 1'b0};
    save_prod = 16'(span10) * RECIP_THREE;
    hd_saved      = hd;
    hd_saved.prog = save_prod[15:9];
  end

  // Operations that load a result into the output register
  assign emit = (cmd.op == prq_pkg::OP_INSERT) || (cmd.op == prq_pkg::OP_REJECT) ||
                (cmd.op == prq_pkg::OP_IDLE) || (cmd.op == prq_pkg::OP_IDLE_EMPTY) ||
                (cmd.op == prq_pkg::OP_TICK) || (cmd.op == prq_pkg::OP_PREEMPT);

  // Write and read port selection
  always_comb begin
    we = 1'b0;
    wa = head;
    wd = cur;
    ra = head;
    case (cmd.op)
      prq_pkg::OP_INSERT: begin
        we = 1'b1;
        wa = phys(head, count);
        wd = new_task;
      end
      prq_pkg::OP_PREEMPT: begin
        we = 1'b1;
        wa = head;
        wd = hd_saved;
      end
      prq_pkg::OP_SORT_RD_I: begin
        ra = phys(head, si);
      end
      prq_pkg::OP_SORT_LD_I: begin
        ra = phys(head, si + CNT_W'(1));
      end
      prq_pkg::OP_SORT_CMP: begin
        we = do_swap;
        wa = phys(head, sj);
        wd = cur;
        ra = phys(head, sj + CNT_W'(1));
      end
      prq_pkg::OP_SORT_WB: begin
        we = 1'b1;
        wa = phys(head, si);
        wd = cur;
      end
      default: begin
        ra = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= req_data;
      si   <= '0;
    end
    case (cmd.op)
      prq_pkg::OP_SORT_LD_I: begin
        cur <= rd_data;
        sj  <= si + CNT_W'(1);
      end
      prq_pkg::OP_SORT_CMP: begin
        if (do_swap) begin
          cur <= rd_data;
        end
        sj <= sj + CNT_W'(1);
      end
      prq_pkg::OP_SORT_WB: begin
        si <= si + CNT_W'(1);
      end
      prq_pkg::OP_DISPATCH: begin
        hd <= rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      next_id    <= 16'd1;
      needs_sort <= 1'b0;
      running    <= 1'b0;
      bar        <= prq_pkg::BAR_START;
      rsp_valid  <= 1'b0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (cmd.op)
        prq_pkg::OP_INSERT: begin
          count      <= count + CNT_W'(1);
          next_id    <= next_id + 16'd1;
          needs_sort <= 1'b1;
          rsp_data   <= '{event_res: prq_pkg::EV_INSERTED, task_id: new_task.id,
                          task_priority: new_task.prio, task_progress: new_task.prog,
                          task_weight: new_task.wgt, bar_position: bar_idle,
                          queue_count: cnt_plus};
        end
        prq_pkg::OP_REJECT, prq_pkg::OP_IDLE: begin
          rsp_data  <= '{event_res: (cmd.op == prq_pkg::OP_REJECT) ? prq_pkg::EV_FULL
                                                                    : prq_pkg::EV_IDLE,
                         task_id: 16'd0, task_priority: 4'd0, task_progress: 7'd0,
                         task_weight: 9'd0, bar_position: bar_idle,
                         queue_count: 6'(count)};
        end
        prq_pkg::OP_IDLE_EMPTY: begin
          running   <= 1'b0;
          bar       <= prq_pkg::BAR_START;
          rsp_data  <= '{event_res: prq_pkg::EV_IDLE, task_id: 16'd0, task_priority: 4'd0,
                         task_progress: 7'd0, task_weight: 9'd0, bar_position: 6'd0,
                         queue_count: 6'(count)};
        end
        prq_pkg::OP_RD_HEAD: begin
          needs_sort <= 1'b0;
        end
        prq_pkg::OP_DISPATCH: begin
          running <= 1'b1;
          bar     <= bar_start;
        end
        prq_pkg::OP_TICK: begin
          if (bar_adv >= prq_pkg::BAR_END) begin
            head     <= phys(head, CNT_W'(1));
            count    <= count - CNT_W'(1);
            running  <= 1'b0;
            bar      <= prq_pkg::BAR_START;
            rsp_data <= '{event_res: prq_pkg::EV_FINISHED, task_id: hd.id,
                          task_priority: hd.prio, task_progress: hd.prog,
                          task_weight: hd.wgt, bar_position: prq_pkg::BAR_END,
                          queue_count: cnt_minus};
          end else begin
            bar      <= bar_adv;
            rsp_data <= '{event_res: prq_pkg::EV_ADVANCED, task_id: hd.id,
                          task_priority: hd.prio, task_progress: hd.prog,
                          task_weight: hd.wgt, bar_position: bar_adv,
                          queue_count: 6'(count)};
          end
        end
        prq_pkg::OP_PREEMPT: begin
          running   <= 1'b0;
          bar       <= prq_pkg::BAR_START;
          rsp_data  <= '{event_res: prq_pkg::EV_PREEMPTED, task_id: hd_saved.id,
                         task_priority: hd_saved.prio, task_progress: hd_saved.prog,
                         task_weight: hd_saved.wgt, bar_position: bar_adv,
                         queue_count: 6'(count)};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.mode     = item.mode;
    sts.full     = (count == CNT_W'(QUEUE_DEPTH));
    sts.empty    = (count == '0);
    sts.running  = running;
    sts.sort_due = needs_sort && (count > CNT_W'(1));
    sts.j_last   = ((CNT_W+1)'(sj) + (CNT_W+1)'(1)) >= (CNT_W+1)'(count);
    sts.i_last   = ((CNT_W+1)'(si) + (CNT_W+1)'(2)) >= (CNT_W+1)'(count);
    sts.out_free = !rsp_valid || rsp_ready;
  end

endmodule

`default_nettype wire

@@ hdl/priority_ready_queue_with_progress.sv @@
// Priority ready queue with a per-task progress bar.
// Request channel (req_valid/req_ready/req_data): one item per command -
// insert a task, tick the running task one bar step (dispatching the head first if none runs), or preempt it.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one item per
// request, in request order, from a registered output stage.
// An item is taken when the controller is idle; insert, preempt, idle
// answers and a tick of a running task are executed in the execute state
// and registered into the output stage, and the next request can be taken in the cycle in which that result shows.
// A tick that dispatches a new head steps through the read-head, dispatch
// and tick states; if tasks were inserted since the last dispatch the
// exchange sort runs first, its pace set by the single read and single
// write port of the task store.
// A request is accepted while the previous result still waits; if the
// receiver stalls, processing holds at the point where it would emit.
// Reset empties the queue, stops the running task, restarts ids at one.
// The task store needs no clearing: only data from live slots is ever used.
`default_nettype none

module priority_ready_queue_with_progress #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_ready,
  input  prq_pkg::req_item_t  req_data,
  output logic                rsp_valid,
  input  wire                 rsp_ready,
  output prq_pkg::rsp_item_t  rsp_data
);

  prq_pkg::cmd_t    cmd;
  prq_pkg::status_t sts;

  // Sequencer: decodes each item, steps the sort, gates result emission
  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Task store, head cache, bar arithmetic and output register
  prq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_data  (req_data),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

  // A result is only loaded when the output stage can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == prq_pkg::OP_INSERT || cmd.op == prq_pkg::OP_REJECT ||
     cmd.op == prq_pkg::OP_IDLE || cmd.op == prq_pkg::OP_IDLE_EMPTY ||
     cmd.op == prq_pkg::OP_TICK || cmd.op == prq_pkg::OP_PREEMPT) |-> sts.out_free)
    else $error("result emitted while output stage busy");

  // One item in flight: ready drops after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while busy");

  // A running task always sits at the head of a non-empty queue
  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    sts.running |-> !sts.empty)
    else $error("running with empty queue");

  // The sort never reorders the queue under a running task
  a_sort_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == prq_pkg::OP_SORT_CMP || cmd.op == prq_pkg::OP_SORT_WB) |-> !sts.running)
    else $error("sort while task running");

endmodule

`default_nettype wire
